// ===== rtl/core/tcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpr_pkg
// command codes and the glyph table for the text console page renderer
// ----------------------------------------------------------------------------
package tcpr_pkg;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_EOS  = 2'd1;
  localparam logic [1:0] CMD_FILL = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  // glyph columns 1..5 packed as {c5, c4, c3, c2, c1}; columns 0, 6 and 7 are blank
  typedef logic [39:0] glyph_cols_t;

  function automatic glyph_cols_t glyph_cols(input logic [7:0] code);
    logic [6:0]  idx;
    glyph_cols_t g;
    idx = 7'd0;
    if (!code[7] && code >= FIRST_CODE) begin
      idx = 7'(code - FIRST_CODE);
    end
    case (idx)
      7'd0:  g = 40'h00_00_00_00_00;
      7'd1:  g = 40'h00_00_00_5F_00;
      7'd2:  g = 40'h00_07_00_07_00;
      7'd3:  g = 40'h14_7F_14_7F_14;
      7'd4:  g = 40'h12_2A_7F_2A_24;
      7'd5:  g = 40'h62_64_08_13_23;
      7'd6:  g = 40'h50_22_55_49_36;
      7'd7:  g = 40'h00_00_03_05_00;
      7'd8:  g = 40'h00_00_41_22_1C;
      7'd9:  g = 40'h00_00_1C_22_41;
      7'd10: g = 40'h08_2A_1C_2A_08;
      7'd11: g = 40'h08_08_3E_08_08;
      7'd12: g = 40'h00_00_00_60_A0;
      7'd13: g = 40'h08_08_08_08_08;
      7'd14: g = 40'h00_00_00_60_60;
      7'd15: g = 40'h02_04_08_10_20;
      7'd16: g = 40'h3E_45_49_51_3E;
      7'd17: g = 40'h00_40_7F_42_00;
      7'd18: g = 40'h46_49_49_51_62;
      7'd19: g = 40'h36_49_49_41_22;
      7'd20: g = 40'h10_7F_12_14_18;
      7'd21: g = 40'h39_45_45_45_27;
      7'd22: g = 40'h30_49_49_4A_3C;
      7'd23: g = 40'h03_05_09_71_01;
      7'd24: g = 40'h36_49_49_49_36;
      7'd25: g = 40'h1E_29_49_49_06;
      7'd26: g = 40'h00_00_36_36_00;
      7'd27: g = 40'h00_00_6C_AC_00;
      7'd28: g = 40'h00_41_22_14_08;
      7'd29: g = 40'h14_14_14_14_14;
      7'd30: g = 40'h00_08_14_22_41;
      7'd31: g = 40'h06_09_51_01_02;
      7'd32: g = 40'h3E_41_79_49_32;
      7'd33: g = 40'h7E_09_09_09_7E;
      7'd34: g = 40'h36_49_49_49_7F;
      7'd35: g = 40'h22_41_41_41_3E;
      7'd36: g = 40'h1C_22_41_41_7F;
      7'd37: g = 40'h41_49_49_49_7F;
      7'd38: g = 40'h01_09_09_09_7F;
      7'd39: g = 40'h72_51_41_41_3E;
      7'd40: g = 40'h7F_08_08_08_7F;
      7'd41: g = 40'h00_00_41_7F_41;
      7'd42: g = 40'h01_3F_41_40_20;
      7'd43: g = 40'h41_22_14_08_7F;
      7'd44: g = 40'h40_40_40_40_7F;
      7'd45: g = 40'h7F_02_0C_02_7F;
      7'd46: g = 40'h7F_10_08_04_7F;
      7'd47: g = 40'h3E_41_41_41_3E;
      7'd48: g = 40'h06_09_09_09_7F;
      7'd49: g = 40'h5E_21_51_41_3E;
      7'd50: g = 40'h46_29_19_09_7F;
      7'd51: g = 40'h32_49_49_49_26;
      7'd52: g = 40'h01_01_7F_01_01;
      7'd53: g = 40'h3F_40_40_40_3F;
      7'd54: g = 40'h1F_20_40_20_1F;
      7'd55: g = 40'h3F_40_38_40_3F;
      7'd56: g = 40'h63_14_08_14_63;
      7'd57: g = 40'h03_04_78_04_03;
      7'd58: g = 40'h43_45_49_51_61;
      7'd59: g = 40'h00_00_41_41_7F;
      7'd60: g = 40'h20_10_08_04_02;
      7'd61: g = 40'h00_00_7F_41_41;
      7'd62: g = 40'h04_02_01_02_04;
      7'd63: g = 40'h80_80_80_80_80;
      7'd64: g = 40'h00_00_04_02_01;
      7'd65: g = 40'h78_54_54_54_20;
      7'd66: g = 40'h38_44_44_48_7F;
      7'd67: g = 40'h00_28_44_44_38;
      7'd68: g = 40'h7F_48_44_44_38;
      7'd69: g = 40'h18_54_54_54_38;
      7'd70: g = 40'h00_02_09_7E_08;
      7'd71: g = 40'h7C_A4_A4_A4_18;
      7'd72: g = 40'h78_04_04_08_7F;
      7'd73: g = 40'h00_00_00_7D_00;
      7'd74: g = 40'h00_00_7D_84_80;
      7'd75: g = 40'h00_44_28_10_7F;
      7'd76: g = 40'h00_00_40_7F_41;
      7'd77: g = 40'h78_04_18_04_7C;
      7'd78: g = 40'h00_7C_04_08_7C;
      7'd79: g = 40'h00_38_44_44_38;
      7'd80: g = 40'h00_18_24_24_FC;
      7'd81: g = 40'h00_FC_24_24_18;
      7'd82: g = 40'h00_04_08_7C_00;
      7'd83: g = 40'h00_24_54_54_48;
      7'd84: g = 40'h00_00_44_7F_04;
      7'd85: g = 40'h00_7C_40_40_3C;
      7'd86: g = 40'h1C_20_40_20_1C;
      7'd87: g = 40'h3C_40_30_40_3C;
      7'd88: g = 40'h44_28_10_28_44;
      7'd89: g = 40'h00_7C_A0_A0_1C;
      7'd90: g = 40'h44_4C_54_64_44;
      7'd91: g = 40'h00_00_41_36_08;
      7'd92: g = 40'h00_00_00_7F_00;
      7'd93: g = 40'h00_00_08_36_41;
      7'd94: g = 40'h01_02_01_01_02;
      7'd95: g = 40'h00_02_05_05_02;
      default: g = 40'h00_00_00_00_00;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/tcpr_in_if.sv =====
// ----------------------------------------------------------------------------
// tcpr_in_if
// command channel of the text console page renderer
// ----------------------------------------------------------------------------
interface tcpr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic       advance_line;
  logic [7:0] fill_value;
  logic [2:0] read_page;
  logic [7:0] read_column;

  modport source (
    output valid, command, char_code, advance_line, fill_value, read_page, read_column,
    input  ready
  );
  modport sink (
    input  valid, command, char_code, advance_line, fill_value, read_page, read_column,
    output ready
  );
endinterface

// ===== rtl/core/tcpr_out_if.sv =====
// ----------------------------------------------------------------------------
// tcpr_out_if
// result channel of the text console page renderer
// ----------------------------------------------------------------------------
interface tcpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] cursor_now;
  logic [3:0] line_now;

  modport source (
    output valid, read_data, cursor_now, line_now,
    input  ready
  );
  modport sink (
    input  valid, read_data, cursor_now, line_now,
    output ready
  );
endinterface

// ===== rtl/core/tcpr_ram.sv =====
// ----------------------------------------------------------------------------
// tcpr_ram
// generic memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module tcpr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1056
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/text_console_page_renderer.sv =====
// ----------------------------------------------------------------------------
// text_console_page_renderer
// text console that draws 8-column glyphs into a page-organized frame memory
// ----------------------------------------------------------------------------
// in_ch carries one command per item: put character, end of string, fill
// screen or read byte. out_ch returns one result per item: the byte read
// (zero for other commands), the cursor column and the line count.
// The frame memory has one write and one read port; all work is sequenced
// through it, one byte per cycle, and in_ch.ready is high only when idle,
// so one item is taken at a time and the next can follow the result load.
// What each command does once taken, before its result is loaded:
//   put character: writes the glyph columns at the cursor in turn, stopping
//                  when the line fills; writes nothing when already full
//   end of string: goes straight to the result
//   read byte:     reads the frame memory, then loads the result
//   fill screen:   writes the fill value to all PAGES*WIDTH bytes
// A put character or end of string that scrolls first runs a copy pass over
// the memory (each page moves up, the last page is cleared).
// After reset a clearing pass zeroes the memory and in_ch.ready stays low
// until it ends.
// The result sits in an output register; while out_ch is stalled the block
// still takes and works on the next item, and holds that result until the
// output register frees up.
// ----------------------------------------------------------------------------
module text_console_page_renderer
  import tcpr_pkg::*;
#(
  parameter int PAGES = 8,
  parameter int WIDTH = 132
) (
  input  logic       clk,
  input  logic       rst_n,
  tcpr_in_if.sink    in_ch,
  tcpr_out_if.source out_ch
);

  localparam int NBYTES    = PAGES * WIDTH;
  localparam int AW        = $clog2(NBYTES);
  localparam int CW        = $clog2(WIDTH + 1);
  localparam int LW        = $clog2(PAGES + 1);
  localparam int LAST_BASE = (PAGES - 1) * WIDTH;

  localparam logic [2:0] S_SWEEP  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_DRAW   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]    state_r;
  logic [2:0]    ret_r;
  logic [AW-1:0] cnt_r;
  logic          issue_r;
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;
  logic          pend_zero_r;
  logic [7:0]    sweep_val_r;
  logic [AW-1:0] drw_addr_r;
  logic [2:0]    col_r;
  glyph_cols_t   glyph_r;
  logic [CW-1:0] cursor_r;
  logic [LW-1:0] line_r;
  logic          open_r;
  logic          full_r;
  logic          rd_ok_r;
  logic [7:0]    res_data_r;
  logic          ov_r;
  logic [7:0]    o_data_r;
  logic [7:0]    o_cursor_r;
  logic [3:0]    o_line_r;

  logic          accept;
  logic          at_bottom;
  logic          col_fits;
  logic [LW-1:0] drw_page;
  logic [AW-1:0] drw_start;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  logic [7:0]    glyph_byte;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          out_free;
  logic          out_load;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign at_bottom   = (line_r == LW'(PAGES));
  assign col_fits    = (cursor_r < CW'(WIDTH));
  assign drw_page    = (line_r >= LW'(PAGES)) ? LW'(PAGES - 1) : line_r;
  assign drw_start   = AW'(drw_page * WIDTH + cursor_r);
  assign rd_addr     = AW'(in_ch.read_page * WIDTH + in_ch.read_column);
  assign rd_ok       = (32'(in_ch.read_page) < PAGES) && (32'(in_ch.read_column) < WIDTH);
  assign out_free    = !ov_r || out_ch.ready;
  assign out_load    = (state_r == S_DONE) && out_free;

  always_comb begin
    case (col_r)
      3'd1:    glyph_byte = glyph_r[7:0];
      3'd2:    glyph_byte = glyph_r[15:8];
      3'd3:    glyph_byte = glyph_r[23:16];
      3'd4:    glyph_byte = glyph_r[31:24];
      3'd5:    glyph_byte = glyph_r[39:32];
      default: glyph_byte = BLANK_BYTE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = sweep_val_r;
    case (state_r)
      S_SWEEP: begin
        ram_we = 1'b1;
      end
      S_SCROLL: begin
        ram_we    = pend_r;
        ram_waddr = pend_addr_r;
        ram_wdata = pend_zero_r ? BLANK_BYTE : ram_rdata;
      end
      S_DRAW: begin
        ram_we    = col_fits;
        ram_waddr = drw_addr_r;
        ram_wdata = glyph_byte;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    ram_raddr = (state_r == S_IDLE) ? rd_addr : cnt_r + AW'(WIDTH);
  end

  tcpr_ram #(
    .DATA_W (8),
    .DEPTH  (NBYTES)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      sweep_val_r <= BLANK_BYTE;
      cursor_r    <= CW'(1);
      line_r      <= '0;
      open_r      <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      case (state_r)
        S_SWEEP: begin
          if (cnt_r == AW'(NBYTES - 1)) begin
            state_r <= ret_r;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_data_r <= BLANK_BYTE;
            cnt_r      <= '0;
            issue_r    <= 1'b1;
            pend_r     <= 1'b0;
            case (in_ch.command)
              CMD_PUT: begin
                open_r     <= 1'b1;
                glyph_r    <= glyph_cols(in_ch.char_code);
                col_r      <= '0;
                drw_addr_r <= drw_start;
                if (!open_r && at_bottom) begin
                  state_r <= S_SCROLL;
                  ret_r   <= full_r ? S_DONE : S_DRAW;
                end else begin
                  state_r <= full_r ? S_DONE : S_DRAW;
                end
              end
              CMD_EOS: begin
                if (in_ch.advance_line) begin
                  if (!at_bottom) begin
                    line_r <= line_r + 1'b1;
                  end
                  cursor_r <= CW'(1);
                end
                open_r  <= 1'b0;
                full_r  <= 1'b0;
                ret_r   <= S_DONE;
                state_r <= (!open_r && at_bottom) ? S_SCROLL : S_DONE;
              end
              CMD_FILL: begin
                sweep_val_r <= in_ch.fill_value;
                line_r      <= '0;
                cursor_r    <= CW'(1);
                open_r      <= 1'b0;
                full_r      <= 1'b0;
                ret_r       <= S_DONE;
                state_r     <= S_SWEEP;
              end
              default: begin
                rd_ok_r <= rd_ok;
                state_r <= S_READ;
              end
            endcase
          end
        end
        S_SCROLL: begin
          pend_r <= issue_r;
          if (issue_r) begin
            pend_addr_r <= cnt_r;
            pend_zero_r <= (32'(cnt_r) >= LAST_BASE);
            if (cnt_r == AW'(NBYTES - 1)) begin
              issue_r <= 1'b0;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          if (pend_r && pend_addr_r == AW'(NBYTES - 1)) begin
            state_r <= ret_r;
          end
        end
        S_DRAW: begin
          if (col_fits) begin
            cursor_r   <= cursor_r + 1'b1;
            drw_addr_r <= drw_addr_r + 1'b1;
            col_r      <= col_r + 1'b1;
            if (col_r == 3'd7) begin
              state_r <= S_DONE;
            end
          end else begin
            full_r  <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_READ: begin
          res_data_r <= rd_ok_r ? ram_rdata : BLANK_BYTE;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            o_data_r   <= res_data_r;
            o_cursor_r <= 8'(cursor_r);
            o_line_r   <= 4'(line_r);
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.read_data  = o_data_r;
  assign out_ch.cursor_now = o_cursor_r;
  assign out_ch.line_now   = o_line_r;

endmodule

// ===== rtl/core/tcpr_checker.sv =====
// ----------------------------------------------------------------------------
// tcpr_checker
// port-level checks for the text console page renderer
// ----------------------------------------------------------------------------
module tcpr_checker #(
  parameter int PAGES = 8
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic [7:0] out_cursor_now,
  input logic [3:0] out_line_now
);

  // busy for the clearing pass right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("item taken during the clearing pass");

  // an item always takes the block out of idle, so ready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an item was taken");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_line_now) <= PAGES)
    else $error("line count beyond the page count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_cursor_now)
                                && $stable(out_line_now))
    else $error("result changed while stalled");

endmodule

bind text_console_page_renderer tcpr_checker #(
  .PAGES (PAGES)
) u_tcpr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_data  (out_ch.read_data),
  .out_cursor_now (out_ch.cursor_now),
  .out_line_now   (out_ch.line_now)
);
